/* rtl/nmea_chk_pkg.sv */
// Shared types, character codes and header lookup for the NMEA sentence checker.
package nmea_chk_pkg;

   localparam int MAX_LEN_DEFAULT = 128;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   localparam logic [2:0] HEADER_LEN = 3'd5;

   typedef enum logic [2:0] {
      TYPE_RMC     = 3'd0,
      TYPE_GGA     = 3'd1,
      TYPE_GSA     = 3'd2,
      TYPE_GSV     = 3'd3,
      TYPE_UNKNOWN = 3'd4
   } sentence_type_type;

   typedef struct packed {
      logic              too_long;
      logic              type_match;
      logic              star_seen;
      logic              checksum_ok;
      sentence_type_type sentence_type;
   } result_type;

   // Expected header character of header k (in type order) at position pos.
   function automatic logic [7:0] header_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (pos)
         3'd0: ch = "G";
         3'd1: ch = "P";
         3'd2: ch = (k == 2'd0) ? 8'("R") : 8'("G");
         3'd3: begin
            case (k)
               2'd0:    ch = "M";
               2'd1:    ch = "G";
               default: ch = "S";
            endcase
         end
         3'd4: begin
            case (k)
               2'd0:    ch = "C";
               2'd3:    ch = "V";
               default: ch = "A";
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

/* rtl/nmea_sentence_checker.sv */
// NMEA 0183 sentence checker: header match, XOR checksum check and length flag.
//
// One character is taken per clock cycle. A character is held in an
// input register and is then folded into the sentence state; a closing line
// feed loads the result register, which then presents the result. The stream
// runs at one character per cycle as long as results are taken. The result
// register is the only point of backpressure.
module nmea_sentence_checker
   import nmea_chk_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] sentence_type, [3] checksum_ok, [4] star_seen,
                                   // [5] type_match, [6] too_long, [7] zero
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_data     // [2:0] wanted_type
);

   localparam int CountWidth = $clog2(MAX_LEN);
   localparam logic [CountWidth-1:0] Limit = CountWidth'(MAX_LEN - 2);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic [2:0]            wanted_type_ff;
   logic                  in_sentence_ff, in_sentence_in;
   logic [2:0]            header_position_ff, header_position_in;
   logic [3:0]            header_candidates_ff, header_candidates_in;
   logic [7:0]            running_xor_ff, running_xor_in;
   logic                  after_star_ff, after_star_in;
   logic [1:0]            digits_taken_ff, digits_taken_in;
   logic [7:0]            received_sum_ff, received_sum_in;
   logic                  digit_error_ff, digit_error_in;
   logic [CountWidth-1:0] char_count_ff, char_count_in;
   logic                  rsp_valid_ff;
   result_type            result_ff, result_in;
   logic                  emit;
   logic                  advance;
   logic [3:0]            nibble;
   logic                  nibble_bad;
   sentence_type_type     found_type;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_type_ff <= 3'd0;
      end else if (csr_valid && csr_ready) begin
         wanted_type_ff <= csr_data;
      end
   end

   always_comb begin
      nibble     = 4'd0;
      nibble_bad = 1'b0;
      if (in_byte_ff >= CHAR_ZERO && in_byte_ff <= CHAR_NINE) begin
         nibble = 4'(in_byte_ff - CHAR_ZERO);
      end else if (in_byte_ff >= CHAR_UPPER_A && in_byte_ff <= CHAR_UPPER_F) begin
         nibble = 4'(in_byte_ff - CHAR_UPPER_A + 8'd10);
      end else begin
         nibble_bad = 1'b1;
      end
   end

   always_comb begin
      found_type = TYPE_UNKNOWN;
      if (header_position_ff >= HEADER_LEN) begin
         for (int k = 3; k >= 0; k--) begin
            if (header_candidates_ff[k]) begin
               found_type = sentence_type_type'(3'(k));
            end
         end
      end
   end

   always_comb begin
      in_sentence_in       = in_sentence_ff;
      header_position_in   = header_position_ff;
      header_candidates_in = header_candidates_ff;
      running_xor_in       = running_xor_ff;
      after_star_in        = after_star_ff;
      digits_taken_in      = digits_taken_ff;
      received_sum_in      = received_sum_ff;
      digit_error_in       = digit_error_ff;
      char_count_in        = char_count_ff;
      emit                 = 1'b0;
      result_in.sentence_type = found_type;
      result_in.checksum_ok   = after_star_ff && digits_taken_ff == 2'd2 && !digit_error_ff
                                && received_sum_ff == running_xor_ff;
      result_in.star_seen     = after_star_ff;
      result_in.type_match    = 3'(found_type) == wanted_type_ff;
      result_in.too_long      = char_count_ff > Limit;
      if (in_byte_ff == CHAR_DOLLAR) begin
         if (!(in_sentence_ff && char_count_ff == '0)) begin
            in_sentence_in       = 1'b1;
            header_position_in   = 3'd0;
            header_candidates_in = 4'hF;
            running_xor_in       = 8'd0;
            after_star_in        = 1'b0;
            digits_taken_in      = 2'd0;
            received_sum_in      = 8'd0;
            digit_error_in       = 1'b0;
            char_count_in        = '0;
         end
      end else if (in_sentence_ff) begin
         if (in_byte_ff == CHAR_LF) begin
            emit           = 1'b1;
            in_sentence_in = 1'b0;
         end else begin
            if (char_count_ff <= Limit) begin
               char_count_in = char_count_ff + 1'b1;
            end
            if (header_position_ff < HEADER_LEN) begin
               for (int k = 0; k < 4; k++) begin
                  if (header_char(2'(k), header_position_ff) != in_byte_ff) begin
                     header_candidates_in[k] = 1'b0;
                  end
               end
               header_position_in = header_position_ff + 3'd1;
            end
            if (!after_star_ff) begin
               if (in_byte_ff == CHAR_STAR) begin
                  after_star_in = 1'b1;
               end else begin
                  running_xor_in = running_xor_ff ^ in_byte_ff;
               end
            end else if (digits_taken_ff < 2'd2) begin
               if (nibble_bad) begin
                  digit_error_in = 1'b1;
               end
               received_sum_in = {received_sum_ff[3:0], nibble};
               digits_taken_in = digits_taken_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff       <= 1'b0;
         header_position_ff   <= 3'd0;
         header_candidates_ff <= 4'hF;
         running_xor_ff       <= 8'd0;
         after_star_ff        <= 1'b0;
         digits_taken_ff      <= 2'd0;
         received_sum_ff      <= 8'd0;
         digit_error_ff       <= 1'b0;
         char_count_ff        <= '0;
      end else if (advance) begin
         in_sentence_ff       <= in_sentence_in;
         header_position_ff   <= header_position_in;
         header_candidates_ff <= header_candidates_in;
         running_xor_ff       <= running_xor_in;
         after_star_ff        <= after_star_in;
         digits_taken_ff      <= digits_taken_in;
         received_sum_ff      <= received_sum_in;
         digit_error_ff       <= digit_error_in;
         char_count_ff        <= char_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         result_ff <= result_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (!in_sentence_ff && rsp_valid_ff))
      else $error("Closing line feed did not produce a result and close the sentence.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && emit))
      else $error("Result appeared without a closing line feed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.checksum_ok && !result_ff.star_seen))
      else $error("Checksum reported good without a star delimiter.");

   assert property (@(posedge clock) disable iff (reset)
      header_position_ff <= HEADER_LEN)
      else $error("Header position ran past the header length.");
`endif

endmodule

/* dv/nmea_result_checker.sv */
// Result checker for the NMEA sentence checker: tracks each sentence and compares its result.
module nmea_result_checker
   import nmea_chk_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [2:0] csr_data,
   output int         outstanding_reports,
   output int         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   result_type expected_reports[$];

   logic [2:0] wanted_type;
   logic       in_sentence;
   int         header_pos;
   logic [3:0] header_alive;
   logic [7:0] xor_acc;
   logic       star_found;
   int         digit_count;
   logic [7:0] sum_received;
   logic       digit_bad;
   int         length_seen;
   int         mismatches = 0;

   function automatic logic [7:0] header_char_at(input int k, input int pos);
      logic [39:0] word;
      case (k)
         0:       word = "GPRMC";
         1:       word = "GPGGA";
         2:       word = "GPGSA";
         default: word = "GPGSV";
      endcase
      return word[8 * (4 - pos) +: 8];
   endfunction

   task automatic open_sentence();
      in_sentence  = 1'b1;
      header_pos   = 0;
      header_alive = 4'hF;
      xor_acc      = 8'h00;
      star_found   = 1'b0;
      digit_count  = 0;
      sum_received = 8'h00;
      digit_bad    = 1'b0;
      length_seen  = 0;
   endtask

   task automatic fold_char(input logic [7:0] ch);
      result_type report;
      logic [3:0] nib;
      int         k;
      if (ch == CHAR_DOLLAR) begin
         if (!(in_sentence && length_seen == 0)) begin
            open_sentence();
         end
      end else if (in_sentence) begin
         if (ch == CHAR_LF) begin
            report.sentence_type = TYPE_UNKNOWN;
            if (header_pos >= HEADER_LEN) begin
               for (k = 3; k >= 0; k--) begin
                  if (header_alive[k]) begin
                     report.sentence_type = sentence_type_type'(3'(k));
                  end
               end
            end
            report.checksum_ok = star_found && digit_count == 2 && !digit_bad &&
                                 sum_received == xor_acc;
            report.star_seen   = star_found;
            report.type_match  = (3'(report.sentence_type) == wanted_type);
            report.too_long    = (length_seen > MAX_LEN - 2);
            expected_reports.push_back(report);
            in_sentence = 1'b0;
         end else begin
            if (length_seen <= MAX_LEN - 2) begin
               length_seen++;
            end
            if (header_pos < HEADER_LEN) begin
               for (k = 0; k < 4; k++) begin
                  if (header_char_at(k, header_pos) != ch) begin
                     header_alive[k] = 1'b0;
                  end
               end
               header_pos++;
            end
            if (!star_found) begin
               if (ch == CHAR_STAR) begin
                  star_found = 1'b1;
               end else begin
                  xor_acc ^= ch;
               end
            end else if (digit_count < 2) begin
               if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                  nib = 4'(ch - CHAR_ZERO);
               end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
                  nib = 4'(ch - CHAR_UPPER_A + 8'd10);
               end else begin
                  nib       = 4'h0;
                  digit_bad = 1'b1;
               end
               sum_received = {sum_received[3:0], nib};
               digit_count++;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic compare_report(input logic [7:0] data);
      result_type want;
      result_type got;
      if (expected_reports.size() == 0) begin
         $error("result transfer %h arrived with no sentence closed", data);
         mismatches++;
      end else begin
         want = expected_reports.pop_front();
         got  = result_type'(data[6:0]);
         check_field("sentence_type", 3'(want.sentence_type), 3'(got.sentence_type));
         check_field("checksum_ok", 3'(want.checksum_ok), 3'(got.checksum_ok));
         check_field("star_seen", 3'(want.star_seen), 3'(got.star_seen));
         check_field("type_match", 3'(want.type_match), 3'(got.type_match));
         check_field("too_long", 3'(want.too_long), 3'(got.too_long));
         check_field("padding", 3'd0, 3'(data[7]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wanted_type = 3'd0;
         open_sentence();
         in_sentence = 1'b0;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            wanted_type = csr_data;
         end
         if (req_tvalid && req_tready) begin
            fold_char(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            compare_report(rsp_tdata);
         end
      end
      outstanding_reports <= expected_reports.size();
      mismatch_count      <= mismatches;
   end

endmodule

/* dv/tb_nmea_sentence_checker.sv */
// Testbench top for the NMEA sentence checker: clock, reset, sentence stimulus and verdict.
module tb_nmea_sentence_checker;
   import nmea_chk_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         MAX_LEN     = MAX_LEN_DEFAULT;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         BYTE_TARGET = 1700;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   typedef enum {
      END_GOOD,
      END_BAD,
      END_NO_STAR,
      END_ONE_DIGIT,
      END_LOWER,
      END_JUNK
   } tail_kind_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_data   = 3'd0;

   int outstanding_reports;
   int mismatch_count;
   int cycle_count  = 0;
   int ready_hold   = 0;
   int body_bytes   = 0;
   bit sender_gaps  = 1'b1;
   bit rsp_steady   = 1'b0;

   logic [7:0] sentence_bytes[$];

   nmea_sentence_checker #(
      .MAX_LEN(MAX_LEN)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   nmea_result_checker #(
      .MAX_LEN(MAX_LEN)
   ) i_result_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .outstanding_reports(outstanding_reports),
      .mismatch_count     (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL nmea_sentence_checker");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (rsp_steady) begin
         rsp_tready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!rsp_tready) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 12);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                     $urandom_range(0, 2);
      end
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!sender_gaps || r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) begin
         return CHAR_ZERO + 8'(n);
      end
      return CHAR_UPPER_A + 8'(n) - 8'd10;
   endfunction

   function automatic string header_text(input int k);
      case (k)
         0:       return "GPRMC";
         1:       return "GPGGA";
         2:       return "GPGSA";
         default: return "GPGSV";
      endcase
   endfunction

   task automatic push_char(input logic [7:0] ch);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding_reports != 0);
   endtask

   task automatic write_wanted(input logic [2:0] value);
      settle();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         sentence_bytes.push_back(s[i]);
      end
   endtask

   // The checksum covers everything after the most recent dollar sign.
   task automatic finish_sentence(input tail_kind_type tail, input bit with_cr,
                                  input int trailing);
      logic [7:0] sum;
      logic [7:0] ch;
      sum = 8'h00;
      foreach (sentence_bytes[i]) begin
         sum = (sentence_bytes[i] == CHAR_DOLLAR) ? 8'h00 : sum ^ sentence_bytes[i];
      end
      if (tail == END_BAD) begin
         sum ^= 8'h01 << $urandom_range(0, 7);
      end
      if (tail != END_NO_STAR) begin
         sentence_bytes.push_back(CHAR_STAR);
      end
      case (tail)
         END_GOOD, END_BAD: begin
            sentence_bytes.push_back(hex_char(sum[7:4]));
            sentence_bytes.push_back(hex_char(sum[3:0]));
         end
         END_ONE_DIGIT: begin
            sentence_bytes.push_back(hex_char(sum[7:4]));
         end
         END_LOWER: begin
            sentence_bytes.push_back(hex_char(sum[7:4]) | 8'h20);
            sentence_bytes.push_back(hex_char(sum[3:0]) | 8'h20);
         end
         END_JUNK: begin
            do ch = 8'($urandom_range(0, 255));
            while (ch == CHAR_DOLLAR || ch == CHAR_LF);
            sentence_bytes.push_back(ch);
            sentence_bytes.push_back(hex_char(sum[3:0]));
         end
         default: begin
         end
      endcase
      if (with_cr) begin
         sentence_bytes.push_back(CHAR_CR);
      end
      repeat (trailing) sentence_bytes.push_back(8'($urandom_range(65, 90)));
      sentence_bytes.push_back(CHAR_LF);
      foreach (sentence_bytes[i]) begin
         push_char(sentence_bytes[i]);
      end
      body_bytes += sentence_bytes.size();
      sentence_bytes.delete();
   endtask

   task automatic random_sentence();
      int            r;
      int            len;
      int            k;
      bit            wide;
      logic [7:0]    ch;
      string         hdr;
      tail_kind_type tail;
      put_text("$");
      if ($urandom_range(0, 19) == 0) begin
         put_text("$");
      end
      r = $urandom_range(0, 99);
      if (r < 80) begin
         put_text(header_text($urandom_range(0, 3)));
      end else if (r < 90) begin
         hdr = header_text($urandom_range(0, 3));
         hdr[$urandom_range(0, 4)] = 8'($urandom_range(65, 90));
         put_text(hdr);
      end else begin
         repeat ($urandom_range(0, 5)) sentence_bytes.push_back(8'($urandom_range(65, 90)));
      end
      wide = ($urandom_range(0, 9) == 0);
      len  = ($urandom_range(0, 19) == 0) ? $urandom_range(110, 140) : $urandom_range(0, 20);
      for (k = 0; k < len; k++) begin
         if (wide) begin
            do ch = 8'($urandom_range(0, 255));
            while (ch == CHAR_DOLLAR || ch == CHAR_STAR || ch == CHAR_LF);
         end else begin
            do ch = 8'($urandom_range(32, 126));
            while (ch == CHAR_DOLLAR || ch == CHAR_STAR);
         end
         sentence_bytes.push_back(ch);
      end
      r = $urandom_range(0, 99);
      if (r < 75) begin
         tail = END_GOOD;
      end else if (r < 83) begin
         tail = END_BAD;
      end else if (r < 88) begin
         tail = END_NO_STAR;
      end else if (r < 92) begin
         tail = END_ONE_DIGIT;
      end else if (r < 96) begin
         tail = END_LOWER;
      end else begin
         tail = END_JUNK;
      end
      finish_sentence(tail, $urandom_range(0, 4) != 0,
                      ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
   endtask

   function automatic logic [2:0] phase_wanted(input int phase);
      case (phase)
         0:       return 3'd4;
         1:       return 3'd7;
         2:       return 3'd1;
         3:       return 3'd2;
         4:       return 3'd3;
         5:       return 3'd5;
         6:       return 3'd6;
         7:       return 3'd0;
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   initial begin
      int phase;
      phase = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_wanted(3'd0);
      put_text("$GPRMC,123519,A,4807.038,N");
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GPGGA,092750.000,5321.6802,N");
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GPGSA,A,3,10,07");
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GPGSV,3,1,11");
      finish_sentence(END_GOOD, 1'b0, 0);
      put_text("$GPXYZ,1,2");
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GP");
      finish_sentence(END_NO_STAR, 1'b0, 0);
      put_text("$");
      finish_sentence(END_NO_STAR, 1'b0, 0);
      put_text("$GPGGA,1,2");
      finish_sentence(END_NO_STAR, 1'b1, 0);
      put_text("$GPGSA,3");
      finish_sentence(END_BAD, 1'b1, 0);
      put_text("$GPGSV,ZZ");
      finish_sentence(END_LOWER, 1'b1, 0);
      put_text("$GPRMC,7");
      finish_sentence(END_JUNK, 1'b1, 0);
      put_text("$GPRMC");
      finish_sentence(END_ONE_DIGIT, 1'b1, 0);
      put_text("$$GPRMC,1");
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GPGGA,12$GPGSV,3");
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GPGGA,9");
      finish_sentence(END_GOOD, 1'b1, 3);
      push_char(8'h41);
      push_char(CHAR_LF);
      push_char(CHAR_STAR);
      put_text("$GPGSA,");
      sentence_bytes.push_back(8'h00);
      sentence_bytes.push_back(8'hFF);
      sentence_bytes.push_back(8'h80);
      sentence_bytes.push_back(8'h7F);
      finish_sentence(END_GOOD, 1'b1, 0);
      put_text("$GPRMC,");
      repeat (130) sentence_bytes.push_back(8'($urandom_range(65, 90)));
      finish_sentence(END_GOOD, 1'b1, 0);
      write_wanted(3'd7);
      put_text("$GPGSV,1");
      finish_sentence(END_GOOD, 1'b1, 0);
      write_wanted(3'd4);
      put_text("$GPABC");
      finish_sentence(END_GOOD, 1'b1, 0);
      write_wanted(3'd3);
      put_text("$GPGSV,4");
      finish_sentence(END_GOOD, 1'b1, 0);

      while (body_bytes < BYTE_TARGET) begin
         write_wanted(phase_wanted(phase));
         sender_gaps = ($urandom_range(0, 3) != 0);
         rsp_steady  = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(6, 16)) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(1, 6)) push_char(8'($urandom_range(0, 255)));
            end
            random_sentence();
            if ($urandom_range(0, 19) == 0) begin
               settle();
            end
         end
         phase++;
      end

      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS nmea_sentence_checker");
      end else begin
         $display("FAIL nmea_sentence_checker");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/nmea_chk_pkg.sv
rtl/nmea_sentence_checker.sv
dv/nmea_result_checker.sv
dv/tb_nmea_sentence_checker.sv
